// ===== hdl/dott_pkg.sv =====
// Package for the deadline ordered timer table: payload structs, opcodes, status codes
// and size constants. Used by every file in the hdl folder.
package dott_pkg;

    localparam int unsigned DefSlots    = 16;
    localparam int unsigned DefTimeBits = 48;
    localparam logic [31:0] WindowReset = 32'd3600000;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_CANCEL  = 3'd1,
        OP_REFRESH = 3'd2,
        OP_RESET   = 3'd3,
        OP_QUERY   = 3'd4,
        OP_EXPIRE  = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [47:0] now_ms;
        logic [3:0]  handle;
        logic [31:0] period_ms;
        logic        recurring;
        logic        count_now;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  timer_handle;
        logic [47:0] remaining_ms;
        logic        front_changed;
        logic        expired_valid;
        logic        has_timers;
        logic        last;
    } result_t;

endpackage

// ===== hdl/deadline_ordered_timer_table.sv =====
// Top level of the deadline ordered timer table: command sequencer around the slot memory.
// Depends on dott_pkg and dott_slot_mem.
//
// A command is taken when start is high and busy is low; busy then stays high until
// the last result is shown and falls in that same cycle. Every result is on result for
// one cycle with done high and cannot be held off. Cancel, refresh, unknown opcodes, an
// add to a full table and a reset that changes nothing or names an inactive slot go
// from S_RD through S_CHECK and S_SCAN_END to the result without a scan. Add, query and
// any other reset scan every slot through the single read port of the slot memory. Expire
// first scans to mark the due slots, then scans once per expired timer to find the next
// in (deadline, slot) order. No clearing pass is needed after reset: the active and
// recurring bits are flip-flops.
module deadline_ordered_timer_table
    import dott_pkg::*;
#(
    parameter int unsigned SLOTS     = DefSlots,
    parameter int unsigned TIME_BITS = DefTimeBits
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  cmd_t        cmd,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam int unsigned TW = TIME_BITS;
    localparam int unsigned DW = TW + 33;
    localparam logic [TW-1:0] TMAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHECK, S_SCAN, S_SCAN_END, S_WRITE, S_EMIT, S_REARM
    } state_t;

    state_t        state_reg;
    cmd_t          cmd_reg;
    logic [TW-1:0] now_reg;
    logic [31:0]   window_reg;
    logic [SLOTS-1:0] active_reg, due_reg, rep_reg;
    logic          notice_reg, roll_reg;
    logic [TW-1:0] last_exp_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] sidx_reg;
    logic          pend_reg;
    logic [AW-1:0] pidx_reg;
    logic          best_v_reg;
    logic [AW-1:0] best_reg;
    logic [TW-1:0] best_dl_reg;
    logic          busy_reg, done_reg;
    result_t       res_reg;
    logic          mark_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [TW-1:0] rd_dl;
    logic [31:0]   rd_per;
    logic          rd_rep;

    assign rd_dl  = rdata[DW-1 -: TW];
    assign rd_per = rdata[32:1];
    assign rd_rep = rdata[0];

    dott_slot_mem #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [31:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {{(TW-31){1'b0}}, b};
        return s[TW] ? TMAX : s[TW-1:0];
    endfunction

    // Handle decoding and lowest free slot.
    logic          h_ok;
    logic [AW-1:0] h_idx;
    logic          in_h_ok;
    logic          free_v;
    logic [AW-1:0] free_idx;
    assign h_ok    = {28'd0, cmd_reg.handle} < 32'(SLOTS);
    assign h_idx   = h_ok ? AW'(cmd_reg.handle) : '0;
    assign in_h_ok = {28'd0, cmd.handle} < 32'(SLOTS);

    always_comb
    begin
        free_v   = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_v   = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    // Arithmetic on the slot that was read.
    logic [TW-1:0] now_t, start_t, new_dl;
    logic          unchanged;
    assign now_t     = now_reg;
    assign start_t   = cmd_reg.count_now ? now_t :
                       (rd_dl >= TW'(rd_per) ? rd_dl - TW'(rd_per) : '0);
    assign unchanged = h_ok && !cmd_reg.count_now && (cmd_reg.period_ms == rd_per);

    // Scan candidate: the slot whose read data just arrived.
    logic          cand, better;
    assign cand   = pend_reg && ((op_t'(cmd_reg.opcode) == OP_EXPIRE) ? due_reg[pidx_reg]
                                                                      : active_reg[pidx_reg]);
    assign better = !best_v_reg || (rd_dl < best_dl_reg);
    assign new_dl  = sat_add(start_t, cmd_reg.period_ms);

    logic roll_now;
    assign roll_now = (last_exp_reg >= TW'(window_reg)) &&
                      (now_t < last_exp_reg - TW'(window_reg));

    // Memory port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = h_idx;
        wdata = {rd_dl, rd_per, rd_rep};
        raddr = (state_reg == S_SCAN) ? sidx_reg : h_idx;
        case (state_reg)
            S_IDLE:
            begin
                raddr = in_h_ok ? AW'(cmd.handle) : '0;
            end
            S_CHECK:
            begin
                case (op_t'(cmd_reg.opcode))
                    OP_ADD:
                    begin
                        we    = free_v;
                        waddr = free_idx;
                        wdata = {sat_add(now_t, cmd_reg.period_ms), cmd_reg.period_ms,
                                 cmd_reg.recurring};
                    end
                    OP_REFRESH:
                    begin
                        we    = h_ok && active_reg[h_idx];
                        wdata = {sat_add(now_t, rd_per), rd_per, rd_rep};
                    end
                    OP_RESET:
                    begin
                        we    = !unchanged && h_ok && active_reg[h_idx];
                        wdata = {new_dl, cmd_reg.period_ms, rd_rep};
                    end
                    default:
                    begin
                        we = 1'b0;
                    end
                endcase
            end
            S_REARM:
            begin
                we    = rd_rep;
                waddr = best_reg;
                wdata = {sat_add(now_t, rd_per), rd_per, rd_rep};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
        if (state_reg == S_EMIT)
        begin
            raddr = best_reg;
        end
    end

    // Sequencer: state, slot bookkeeping and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            window_reg   <= WindowReset;
            active_reg   <= '0;
            due_reg      <= '0;
            rep_reg      <= '0;
            notice_reg   <= 1'b0;
            roll_reg     <= 1'b0;
            last_exp_reg <= '0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            best_v_reg   <= 1'b0;
            mark_reg     <= 1'b0;
            cnt_reg      <= '0;
            sidx_reg     <= '0;
            pidx_reg     <= '0;
            best_reg     <= '0;
            best_dl_reg  <= '0;
            cmd_reg      <= '0;
            now_reg      <= '0;
            res_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= cmd;
                        now_reg   <= TW'(cmd.now_ms);
                        busy_reg  <= 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    res_reg      <= '0;
                    res_reg.last <= 1'b1;
                    sidx_reg     <= '0;
                    cnt_reg      <= '0;
                    pend_reg     <= 1'b0;
                    best_v_reg   <= 1'b0;
                    mark_reg     <= 1'b0;
                    state_reg    <= S_SCAN_END;
                    case (op_t'(cmd_reg.opcode))
                        OP_ADD:
                        begin
                            if (!free_v)
                            begin
                                res_reg.status <= ST_FULL;
                            end
                            else
                            begin
                                active_reg[free_idx]  <= 1'b1;
                                rep_reg[free_idx]     <= cmd_reg.recurring;
                                res_reg.timer_handle  <= 4'(free_idx);
                                best_reg              <= free_idx;
                                state_reg             <= S_SCAN;
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (h_ok && active_reg[h_idx])
                            begin
                                active_reg[h_idx] <= 1'b0;
                            end
                            else
                            begin
                                res_reg.status <= ST_INACTIVE;
                            end
                        end
                        OP_REFRESH:
                        begin
                            if (!(h_ok && active_reg[h_idx]))
                            begin
                                res_reg.status <= ST_INACTIVE;
                            end
                        end
                        OP_RESET:
                        begin
                            if (!unchanged)
                            begin
                                if (!(h_ok && active_reg[h_idx]))
                                begin
                                    res_reg.status <= ST_INACTIVE;
                                end
                                else
                                begin
                                    best_reg  <= h_idx;
                                    state_reg <= S_SCAN;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            notice_reg <= 1'b0;
                            state_reg  <= S_SCAN;
                        end
                        OP_EXPIRE:
                        begin
                            last_exp_reg <= now_t;
                            roll_reg     <= roll_now;
                            mark_reg     <= 1'b1;
                            state_reg    <= S_SCAN;
                        end
                        default:
                        begin
                            res_reg.status <= ST_OK;
                        end
                    endcase
                end
                S_SCAN:
                begin
                    // Issue one read a cycle; evaluate the slot read last cycle.
                    if (cnt_reg < CW'(SLOTS))
                    begin
                        sidx_reg <= (cnt_reg == CW'(SLOTS - 1)) ? '0 : sidx_reg + AW'(1);
                        pidx_reg <= sidx_reg;
                        pend_reg <= 1'b1;
                        cnt_reg  <= cnt_reg + CW'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        if (mark_reg)
                        begin
                            due_reg[pidx_reg] <= active_reg[pidx_reg] &&
                                                 (roll_reg || rd_dl <= now_t);
                        end
                        else if (cand && better)
                        begin
                            best_v_reg  <= 1'b1;
                            best_dl_reg <= rd_dl;
                            if (op_t'(cmd_reg.opcode) != OP_ADD &&
                                op_t'(cmd_reg.opcode) != OP_RESET)
                            begin
                                best_reg <= pidx_reg;
                            end
                            else
                            begin
                                res_reg.front_changed <= (pidx_reg == best_reg);
                            end
                        end
                    end
                    if (!pend_reg && cnt_reg == CW'(SLOTS))
                    begin
                        state_reg <= S_SCAN_END;
                    end
                end
                S_SCAN_END:
                begin
                    state_reg <= S_IDLE;
                    case (op_t'(cmd_reg.opcode))
                        OP_ADD, OP_RESET:
                        begin
                            if (res_reg.status == ST_OK && best_v_reg &&
                                res_reg.front_changed && !notice_reg)
                            begin
                                notice_reg <= 1'b1;
                            end
                            else
                            begin
                                res_reg.front_changed <= 1'b0;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!best_v_reg)
                            begin
                                res_reg.remaining_ms <= '1;
                            end
                            else if (now_t >= best_dl_reg)
                            begin
                                res_reg.remaining_ms <= '0;
                            end
                            else
                            begin
                                res_reg.remaining_ms <= 48'(best_dl_reg - now_t);
                            end
                        end
                        default:
                        begin
                            res_reg.front_changed <= 1'b0;
                        end
                    endcase
                    if (op_t'(cmd_reg.opcode) == OP_EXPIRE)
                    begin
                        if (mark_reg)
                        begin
                            // Due set fixed; now find them one by one.
                            mark_reg   <= 1'b0;
                            cnt_reg    <= '0;
                            sidx_reg   <= '0;
                            best_v_reg <= 1'b0;
                            state_reg  <= (due_reg == '0) ? S_IDLE : S_SCAN;
                            if (due_reg == '0)
                            begin
                                res_reg.has_timers <= (active_reg != '0);
                                done_reg           <= 1'b1;
                                busy_reg           <= 1'b0;
                            end
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        res_reg.has_timers <= (active_reg != '0);
                        done_reg           <= 1'b1;
                        busy_reg           <= 1'b0;
                    end
                end
                S_EMIT:
                begin
                    // Read the chosen slot for its re-arm.
                    due_reg[best_reg] <= 1'b0;
                    state_reg         <= S_REARM;
                end
                S_REARM:
                begin
                    logic [SLOTS-1:0] act_n;
                    act_n = active_reg;
                    if (!rd_rep)
                    begin
                        act_n[best_reg] = 1'b0;
                    end
                    active_reg            <= act_n;
                    res_reg               <= '0;
                    res_reg.timer_handle  <= 4'(best_reg);
                    res_reg.expired_valid <= 1'b1;
                    res_reg.last          <= (due_reg == '0);
                    // Occupancy once the remaining due one-shot timers have gone too.
                    res_reg.has_timers    <= ((act_n & ~(due_reg & ~rep_reg)) != '0);
                    done_reg              <= 1'b1;
                    cnt_reg               <= '0;
                    sidx_reg              <= '0;
                    best_v_reg            <= 1'b0;
                    if (due_reg == '0)
                    begin
                        busy_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hdl/dott_slot_mem.sv =====
// Slot memory of the timer table: deadline, period and recurring flag per slot.
// One synchronous write port and one synchronous read port. Depends on dott_pkg.
module dott_slot_mem
    import dott_pkg::*;
#(
    parameter int unsigned SLOTS     = DefSlots,
    parameter int unsigned TIME_BITS = DefTimeBits,
    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int unsigned DW = TIME_BITS + 33
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [SLOTS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dott_checker.sv =====
// Port-level checker for the deadline ordered timer table, bound to the top level.
// Depends on dott_pkg.
module dott_props
    import dott_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // A taken command raises busy in the next cycle.
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a transfer");

    // The last result of a command frees the block.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last) |-> !busy)
        else $error("busy still high on the last result");

    // No result without a command in progress just before.
    a_res: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in progress");

    // An expired timer result never carries a status or front notice.
    a_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.expired_valid) |-> (result.status == ST_OK && !result.front_changed))
        else $error("expired result with stray fields");

endmodule

bind deadline_ordered_timer_table dott_props u_dott_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
